FILE: rtl/core/spq_pkg.sv
// Shared constants, codes and control types for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CharW = 8;
  localparam int unsigned PrioW = 16;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SHOW   = 1'b1;

  typedef enum logic [1:0] {
    RES_INSERTED = 2'd0,
    RES_LISTED   = 2'd1,
    RES_EMPTY    = 2'd2,
    RES_FULL     = 2'd3
  } res_status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } spq_state_e;

  typedef struct packed {
    logic        write;
    logic        load;
    res_status_e kind;
    logic        last;
    logic        ptr_clr;
    logic        ptr_inc;
  } spq_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic show_last;
    logic out_free;
  } spq_stat_t;

endpackage

FILE: rtl/core/spq_if.sv
// Valid/ready channel interfaces for the request and result words.
interface spq_in_if
  import spq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             func;
  logic [CharW-1:0] item_char;
  logic [PrioW-1:0] priority_req;

  modport source (output valid, output func, output item_char, output priority_req,
                  input ready);
  modport sink (input valid, input func, input item_char, input priority_req,
                output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;
  logic [PrioW-1:0] out_priority;
  logic [1:0]       status;
  logic             last;

  modport source (output valid, output out_char, output out_priority, output status,
                  output last, input ready);
  modport sink (input valid, input out_char, input out_priority, input status,
                input last, output ready);
endinterface

FILE: rtl/core/spq_ctrl.sv
// Controller state machine: accepts request words and sequences the show stream.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_func_i,
  output logic      in_ready_o,
  input  spq_stat_t stat_i,
  output spq_cmd_t  cmd_o
);

  spq_state_e state_q, state_d;
  logic       fire;

  assign fire = in_valid_i && stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (fire && in_func_i == FUNC_SHOW && !stat_i.fill_zero) begin
          state_d = ST_SHOW;
        end
      end
      ST_SHOW: begin
        if (stat_i.out_free && stat_i.show_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.kind    = RES_INSERTED;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (fire) begin
          if (in_func_i == FUNC_INSERT) begin
            cmd_o.load  = 1'b1;
            cmd_o.last  = 1'b1;
            if (stat_i.fill_full) begin
              cmd_o.kind = RES_FULL;
            end else begin
              cmd_o.kind  = RES_INSERTED;
              cmd_o.write = 1'b1;
            end
          end else if (stat_i.fill_zero) begin
            cmd_o.load = 1'b1;
            cmd_o.last = 1'b1;
            cmd_o.kind = RES_EMPTY;
          end else begin
            cmd_o.ptr_clr = 1'b1;
          end
        end
      end
      ST_SHOW: begin
        // advance one entry each time the output register frees up
        if (stat_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.kind    = RES_LISTED;
          cmd_o.last    = stat_i.show_last;
          cmd_o.ptr_inc = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/spq_datapath.sv
// Datapath: sorted slot row with parallel insert cells, read pointer and result register.
module spq_datapath
  import spq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CharW-1:0] item_char_i,
  input  logic [PrioW-1:0] priority_req_i,
  input  spq_cmd_t         cmd_i,
  output spq_stat_t        stat_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [CharW-1:0] out_char_o,
  output logic [PrioW-1:0] out_priority_o,
  output logic [1:0]       out_status_o,
  output logic             out_last_o
);

  logic [CharW-1:0] slot_char_q [DEPTH];
  logic [PrioW-1:0] slot_prio_q [DEPTH];
  logic [CharW-1:0] slot_char_d [DEPTH];
  logic [PrioW-1:0] slot_prio_d [DEPTH];
  logic [CharW-1:0] head_char [DEPTH];
  logic [PrioW-1:0] head_prio [DEPTH];
  logic [DEPTH-1:0] greater;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic             ov_q;
  logic [CharW-1:0] oc_q;
  logic [PrioW-1:0] op_q;
  logic [1:0]       os_q;
  logic             ol_q;

  // Occupied slots holding a priority strictly above the new one; the row is
  // sorted, so these form a tail and the new word lands at its head.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      greater[i] = (CntW'(i) < fill_q) && (slot_prio_q[i] > priority_req_i);
    end
  end

  // Within the tail, each run of equal priorities takes the carry at its first
  // slot and passes its own front entry on to the start of the next run; the
  // last carry drops into the free slot. head_* holds the front entry of the
  // run that a slot belongs to.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic             same_run;
    logic [CharW-1:0] cin_char;
    logic [PrioW-1:0] cin_prio;
    if (g == 0) begin : g_head
      assign same_run     = 1'b0;
      assign cin_char     = item_char_i;
      assign cin_prio     = priority_req_i;
      assign head_char[g] = slot_char_q[g];
      assign head_prio[g] = slot_prio_q[g];
    end else begin : g_body
      assign same_run     = greater[g-1] && (slot_prio_q[g] == slot_prio_q[g-1]);
      assign cin_char     = greater[g-1] ? head_char[g-1] : item_char_i;
      assign cin_prio     = greater[g-1] ? head_prio[g-1] : priority_req_i;
      assign head_char[g] = same_run ? head_char[g-1] : slot_char_q[g];
      assign head_prio[g] = same_run ? head_prio[g-1] : slot_prio_q[g];
    end

    always_comb begin
      slot_char_d[g] = slot_char_q[g];
      slot_prio_d[g] = slot_prio_q[g];
      if (cmd_i.write) begin
        if ((greater[g] && !same_run) || CntW'(g) == fill_q) begin
          slot_char_d[g] = cin_char;
          slot_prio_d[g] = cin_prio;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      slot_char_q[g] <= slot_char_d[g];
      slot_prio_q[g] <= slot_prio_d[g];
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.write) begin
      fill_d = fill_q + CntW'(1);
    end
    ptr_d = ptr_q;
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ptr_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
      if (cmd_i.load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // result word: only a listed entry carries slot contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      os_q <= cmd_i.kind;
      ol_q <= cmd_i.last;
      if (cmd_i.kind == RES_LISTED) begin
        oc_q <= slot_char_q[ptr_q];
        op_q <= slot_prio_q[ptr_q];
      end else begin
        oc_q <= '0;
        op_q <= '0;
      end
    end
  end

  assign stat_o.fill_zero = (fill_q == '0);
  assign stat_o.fill_full = (fill_q == CntW'(DEPTH));
  assign stat_o.show_last = (({1'b0, ptr_q} + CntW'(1)) == fill_q);
  assign stat_o.out_free  = !ov_q || out_ready_i;

  assign out_valid_o    = ov_q;
  assign out_char_o     = oc_q;
  assign out_priority_o = op_q;
  assign out_status_o   = os_q;
  assign out_last_o     = ol_q;

endmodule

FILE: rtl/core/sorted_priority_queue_core.sv
// Sorted priority queue: controller plus slot datapath behind valid/ready channels.
// Holds up to DEPTH (character, priority) entries in nondecreasing priority order; a new
// entry goes behind all entries of equal priority. An insert is applied to the slot row in one update:
// every slot compares against the new priority in parallel, and each run of equal
// priorities above the new one hands its front entry on to the start of the next run,
// the last of these landing in the free slot, so equal entries behind the new one may
// change order. One result word follows (status inserted, or full with the store
// unchanged). A show word streams the stored entries from the front, one per cycle while
// the output is ready, through the output register, with last set on the final one, or
// gives a single empty result. While a show is streaming no new word is accepted; with
// the output kept ready, inserts sustain one word per cycle. No clearing pass after reset.
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  spq_in_if.sink   in_i,
  spq_out_if.source out_o
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_char_i    (in_i.item_char),
    .priority_req_i (in_i.priority_req),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_char_o     (out_o.out_char),
    .out_priority_o (out_o.out_priority),
    .out_status_o   (out_o.status),
    .out_last_o     (out_o.last)
  );

endmodule
